/* src/chs_pkg.sv */
`timescale 1ns / 1ps

package chs_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int PCT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_INVALID    = 2'd0;
    localparam logic [1:0] ST_CALIBRATED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATT_TILT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_FLAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRI_TILT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRI_FLAT = 2'd3;

    localparam logic [PCT_W-1:0] ATT_TILT_RST = 7'd32;
    localparam logic [PCT_W-1:0] ATT_FLAT_RST = 7'd14;
    localparam logic [PCT_W-1:0] FRI_TILT_RST = 7'd55;
    localparam logic [PCT_W-1:0] FRI_FLAT_RST = 7'd80;

    // flatness divider: |z|*100 / (|z|+|x|+|y|+1), quotient always below 100
    localparam int DIV_NUM_W = 19;
    localparam int DIV_DEN_W = 14;
    localparam int DIV_Q_W   = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_RCP,
        S_WB,
        S_POS,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_ATT,
        PH_FRI,
        PH_VEL,
        PH_DAMP
    } t_phase;

    typedef struct packed {
        logic   capture;
        logic   exec;
        logic   div_start;
        logic   mul;
        logic   rcp;
        logic   wb;
        logic   pos;
        logic   out_load;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       seen;
        logic       div_done;
    } t_sts;

endpackage

/* src/chs_div.sv */
`timescale 1ns / 1ps

module chs_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [chs_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [chs_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [chs_pkg::DIV_Q_W-1:0]    o_quot
);

    localparam int NUM_W = chs_pkg::DIV_NUM_W;
    localparam int DEN_W = chs_pkg::DIV_DEN_W;
    localparam int Q_W   = chs_pkg::DIV_Q_W;
    localparam int SH_W  = DEN_W + Q_W - 1;
    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [SH_W-1:0]  r_dsh;
    logic [Q_W-1:0]   r_q;

    logic [SH_W-1:0]  w_diff;
    logic             w_ge;

    assign w_ge   = {{(SH_W-NUM_W){1'b0}}, r_rem} >= r_dsh;
    assign w_diff = {{(SH_W-NUM_W){1'b0}}, r_rem} - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, {(Q_W-1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[NUM_W-1:0];
            end
            r_q   <= {r_q[Q_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* src/chs_dp.sv */
`timescale 1ns / 1ps

module chs_dp #(
    parameter int FRAC_BITS = chs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chs_pkg::t_cmd                       i_cmd,
    output chs_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [chs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [chs_pkg::PCT_W-1:0]           i_cfg_data,
    input  logic [1:0]                          i_opcode,
    input  logic [15:0]                         i_heading_raw,
    input  logic [1:0]                          i_compass_status,
    input  logic                                i_accel_valid,
    input  logic signed [12:0]                  i_accel_x,
    input  logic signed [12:0]                  i_accel_y,
    input  logic signed [12:0]                  i_accel_z,
    output logic [8:0]                          o_heading_deg,
    output logic                                o_low_accuracy,
    output logic                                o_has_reading
);

    localparam int PCT_W  = chs_pkg::PCT_W;
    localparam int POS_W  = FRAC_BITS + 9;
    localparam int VEL_W  = FRAC_BITS + 10;
    localparam int PS_W   = VEL_W + 1;
    localparam int MA_W   = VEL_W;
    localparam int MB_W   = 9;
    localparam int PW     = MA_W + MB_W;
    localparam int RN     = FRAC_BITS + 16;
    localparam int RCP_S  = RN + 7;
    localparam int KW     = RCP_S - 6;
    localparam int QW     = RN - 6;
    localparam int VQ_W   = QW + 2;

    localparam logic [POS_W-1:0]        FULL_TURN = POS_W'(360 << FRAC_BITS);
    localparam logic signed [PS_W-1:0]  FT_S      = PS_W'(360 << FRAC_BITS);
    localparam logic signed [VQ_W-1:0]  VEL_HI    = VQ_W'((1 << (VEL_W - 1)) - 1);
    localparam logic signed [VQ_W-1:0]  VEL_LO    = VQ_W'(-(1 << (VEL_W - 1)));
    // reciprocal of 100, exact for every magnitude below 2**RN
    localparam logic [KW-1:0]           RCP_K     =
        KW'(((64'd1 << RCP_S) + 64'd99) / 64'd100);

    logic [PCT_W-1:0] r_att_tilt, r_att_flat, r_fri_tilt, r_fri_flat;

    logic [1:0]         r_op;
    logic [15:0]        r_raw;
    logic [1:0]         r_status;
    logic               r_av;
    logic signed [12:0] r_ax, r_ay, r_az;

    logic [8:0]              r_target;
    logic [POS_W-1:0]        r_pos;
    logic signed [VEL_W-1:0] r_vel;
    logic                    r_seen;
    logic                    r_acc_low;

    logic [PCT_W-1:0]        r_attract;
    logic [PCT_W-1:0]        r_fric;
    logic signed [PW-1:0]    r_prod;
    logic [RN+KW-1:0]        r_rp;
    logic                    r_rneg;

    logic [8:0] r_heading;
    logic       r_low_acc_out;
    logic       r_has_out;

    function automatic logic [12:0] f_abs13(input logic signed [12:0] v);
        return v[12] ? 13'(-v) : 13'(v);
    endfunction

    function automatic logic signed [VEL_W-1:0] f_sat(input logic signed [VQ_W-1:0] v);
        logic signed [VEL_W-1:0] res;
        if (v > VEL_HI) begin
            res = VEL_HI[VEL_W-1:0];
        end else if (v < VEL_LO) begin
            res = VEL_LO[VEL_W-1:0];
        end else begin
            res = v[VEL_W-1:0];
        end
        return res;
    endfunction

    // reading conversion
    logic [16:0] w_cw;
    logic [24:0] w_tprod;
    logic [8:0]  w_target;

    assign w_cw     = 17'h10000 - {1'b0, r_raw};
    assign w_tprod  = {8'd0, w_cw} * 25'd360;
    assign w_target = (w_tprod[24:16] == 9'd360) ? 9'd0 : w_tprod[24:16];

    // flatness
    logic [12:0]                    w_abs_x, w_abs_y, w_abs_z;
    logic [chs_pkg::DIV_DEN_W-1:0]  w_den;
    logic [chs_pkg::DIV_NUM_W-1:0]  w_num;
    logic [chs_pkg::DIV_Q_W-1:0]    w_flat;
    logic                           w_div_done;

    assign w_abs_x = f_abs13(r_ax);
    assign w_abs_y = f_abs13(r_ay);
    assign w_abs_z = f_abs13(r_az);
    assign w_den   = {1'b0, w_abs_z} + {1'b0, w_abs_x} + {1'b0, w_abs_y} + 14'd1;
    assign w_num   = r_av ? ({6'd0, w_abs_z} * 19'd100) : '0;

    chs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_flat)
    );

    // shortest signed angle from position to target
    logic [8:0]        w_smooth;
    logic [9:0]        w_wrap;
    logic [8:0]        w_mod;
    logic signed [9:0] w_delta;

    assign w_smooth = r_pos[POS_W-1:FRAC_BITS];
    assign w_wrap   = {1'b0, r_target} + 10'd540 - {1'b0, w_smooth};
    assign w_mod    = (w_wrap >= 10'd720) ? 9'(w_wrap - 10'd720) :
                      (w_wrap >= 10'd360) ? 9'(w_wrap - 10'd360) : w_wrap[8:0];
    assign w_delta  = $signed({1'b0, w_mod}) - 10'sd180;

    // shared multiplier
    logic signed [7:0]      w_att_diff, w_fri_diff;
    logic signed [MA_W-1:0] w_mul_a;
    logic signed [MB_W-1:0] w_mul_b;
    logic signed [PW-1:0]   w_prod;

    assign w_att_diff = $signed({1'b0, r_att_tilt}) - $signed({1'b0, r_att_flat});
    assign w_fri_diff = $signed({1'b0, r_fri_flat}) - $signed({1'b0, r_fri_tilt});

    always_comb begin
        case (i_cmd.phase)
            chs_pkg::PH_ATT: begin
                w_mul_a = MA_W'(w_att_diff);
                w_mul_b = $signed({2'b0, w_flat});
            end
            chs_pkg::PH_FRI: begin
                w_mul_a = MA_W'(w_fri_diff);
                w_mul_b = $signed({2'b0, w_flat});
            end
            chs_pkg::PH_VEL: begin
                w_mul_a = MA_W'(w_delta);
                w_mul_b = $signed({2'b0, r_attract});
            end
            default: begin
                w_mul_a = r_vel;
                w_mul_b = 9'sd100 - $signed({2'b0, r_fric});
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // divide by 100, truncating toward zero
    logic                  w_neg;
    logic [PW-1:0]         w_mag_full;
    logic [PW+FRAC_BITS-1:0] w_mag_sh;
    logic [RN-1:0]         w_mag;
    logic [RN+KW-1:0]      w_rp;
    logic [QW-1:0]         w_qmag;
    logic signed [QW:0]    w_q;

    assign w_neg      = r_prod[PW-1];
    assign w_mag_full = w_neg ? -r_prod : r_prod;
    assign w_mag_sh   = {w_mag_full, {FRAC_BITS{1'b0}}};
    assign w_mag      = (i_cmd.phase == chs_pkg::PH_VEL) ? w_mag_sh[RN-1:0]
                                                          : w_mag_full[RN-1:0];
    assign w_rp       = w_mag * RCP_K;
    assign w_qmag     = r_rp[RN+KW-1:RCP_S];
    assign w_q        = r_rneg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});

    logic signed [QW:0]      w_att_new, w_fri_new;
    logic signed [VQ_W-1:0]  w_vsum;

    assign w_att_new = $signed({{(QW-6){1'b0}}, r_att_tilt}) - w_q;
    assign w_fri_new = $signed({{(QW-6){1'b0}}, r_fri_tilt}) + w_q;
    assign w_vsum    = VQ_W'(r_vel) + VQ_W'(w_q);

    // position wrap into one turn
    logic signed [PS_W-1:0] w_psum, w_pa, w_pb;

    assign w_psum = $signed({2'b0, r_pos}) + PS_W'(r_vel);
    assign w_pa   = w_psum[PS_W-1] ? (w_psum + FT_S) :
                    (w_psum >= FT_S) ? (w_psum - FT_S) : w_psum;
    assign w_pb   = w_pa[PS_W-1] ? (w_pa + FT_S) :
                    (w_pa >= FT_S) ? (w_pa - FT_S) : w_pa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_tilt <= chs_pkg::ATT_TILT_RST;
            r_att_flat <= chs_pkg::ATT_FLAT_RST;
            r_fri_tilt <= chs_pkg::FRI_TILT_RST;
            r_fri_flat <= chs_pkg::FRI_FLAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                chs_pkg::CFG_ATT_TILT: r_att_tilt <= i_cfg_data;
                chs_pkg::CFG_ATT_FLAT: r_att_flat <= i_cfg_data;
                chs_pkg::CFG_FRI_TILT: r_fri_tilt <= i_cfg_data;
                chs_pkg::CFG_FRI_FLAT: r_fri_flat <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_raw    <= i_heading_raw;
            r_status <= i_compass_status;
            r_av     <= i_accel_valid;
            r_ax     <= i_accel_x;
            r_ay     <= i_accel_y;
            r_az     <= i_accel_z;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.rcp) begin
            r_rp   <= w_rp;
            r_rneg <= w_neg;
        end
        if (i_cmd.wb && i_cmd.phase == chs_pkg::PH_ATT) begin
            r_attract <= w_att_new[PCT_W-1:0];
        end
        if (i_cmd.wb && i_cmd.phase == chs_pkg::PH_FRI) begin
            r_fric <= w_fri_new[PCT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_heading     <= w_smooth;
            r_low_acc_out <= r_acc_low;
            r_has_out     <= r_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_pos     <= '0;
            r_vel     <= '0;
            r_seen    <= 1'b0;
            r_acc_low <= 1'b1;
        end else if (i_cmd.exec) begin
            case (r_op)
                chs_pkg::OP_READ: begin
                    if (r_status != chs_pkg::ST_INVALID) begin
                        r_target  <= w_target;
                        r_acc_low <= (r_status != chs_pkg::ST_CALIBRATED);
                        if (!r_seen) begin
                            r_pos  <= {w_target, {FRAC_BITS{1'b0}}};
                            r_vel  <= '0;
                            r_seen <= 1'b1;
                        end
                    end
                end
                chs_pkg::OP_RESTART: begin
                    r_seen <= 1'b0;
                    r_vel  <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.wb && i_cmd.phase == chs_pkg::PH_VEL) begin
            r_vel <= f_sat(w_vsum);
        end else if (i_cmd.wb && i_cmd.phase == chs_pkg::PH_DAMP) begin
            r_vel <= f_sat(VQ_W'(w_q));
        end else if (i_cmd.pos) begin
            r_pos <= w_pb[POS_W-1:0];
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.seen     = r_seen;
    assign o_sts.div_done = w_div_done;

    assign o_heading_deg  = r_heading;
    assign o_low_accuracy = r_low_acc_out;
    assign o_has_reading  = r_has_out;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < FULL_TURN)
        else $error("position outside one turn");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_op == chs_pkg::OP_RESTART |=> !r_seen && r_vel == '0)
        else $error("restart did not clear reading and velocity");

    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_op == chs_pkg::OP_READ && r_status != chs_pkg::ST_INVALID
        && !r_seen |=> r_seen && r_vel == '0 && r_pos[FRAC_BITS-1:0] == '0)
        else $error("first valid reading did not seed position");

endmodule

/* src/chs_ctrl.sv */
`timescale 1ns / 1ps

module chs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  chs_pkg::t_sts  i_sts,
    output chs_pkg::t_cmd  o_cmd
);

    chs_pkg::t_state r_state, n_state;
    chs_pkg::t_phase r_phase, n_phase;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chs_pkg::S_IDLE;
            r_phase     <= chs_pkg::PH_ATT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        unique case (r_state)
            chs_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = chs_pkg::S_LOAD;
                end
            end
            chs_pkg::S_LOAD: begin
                o_cmd.exec = 1'b1;
                if (i_sts.op == chs_pkg::OP_TICK && i_sts.seen) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = chs_pkg::S_DIV;
                end else begin
                    n_state = chs_pkg::S_OUT;
                end
            end
            chs_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = chs_pkg::S_MUL;
                    n_phase = chs_pkg::PH_ATT;
                end
            end
            chs_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = chs_pkg::S_RCP;
            end
            chs_pkg::S_RCP: begin
                o_cmd.rcp = 1'b1;
                n_state   = chs_pkg::S_WB;
            end
            chs_pkg::S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = chs_pkg::S_MUL;
                unique case (r_phase)
                    chs_pkg::PH_ATT:  n_phase = chs_pkg::PH_FRI;
                    chs_pkg::PH_FRI:  n_phase = chs_pkg::PH_VEL;
                    chs_pkg::PH_VEL:  n_phase = chs_pkg::PH_DAMP;
                    chs_pkg::PH_DAMP: n_state = chs_pkg::S_POS;
                endcase
            end
            chs_pkg::S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = chs_pkg::S_OUT;
            end
            chs_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = chs_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != chs_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == chs_pkg::S_IDLE && i_in_valid |=> r_state == chs_pkg::S_LOAD)
        else $error("accepted item did not start");

    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == chs_pkg::S_DIV && i_sts.div_done
        |=> r_state == chs_pkg::S_MUL && r_phase == chs_pkg::PH_ATT)
        else $error("gain blend did not follow flatness");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == chs_pkg::S_OUT && !i_out_stall
        |=> r_out_valid && r_state == chs_pkg::S_IDLE)
        else $error("result not presented");

endmodule

/* src/compass_heading_smoother.sv */
`timescale 1ns / 1ps
// Reading, restart, idle items and ticks before a reading: capture, load, output write.
// Ticks after a reading: capture, load, serial flatness divider, four phases of shared
// multiply and reciprocal divide by 100 (attract, friction, velocity, damping), position
// wrap, output write. A new item is taken only after the last result has been written.
// A stalled output holds the finished result; the block waits before writing the next.
// Reset (synchronous, active low) restores the default gains and clears the smoother state.

module compass_heading_smoother #(
    parameter int FRAC_BITS = chs_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [15:0]                     i_heading_raw,
    input  logic [1:0]                      i_compass_status,
    input  logic                            i_accel_valid,
    input  logic signed [12:0]              i_accel_x,
    input  logic signed [12:0]              i_accel_y,
    input  logic signed [12:0]              i_accel_z,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [8:0]                      o_heading_deg,
    output logic                            o_low_accuracy,
    output logic                            o_has_reading,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [chs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [chs_pkg::PCT_W-1:0]       i_cfg_data
);

    chs_pkg::t_cmd w_cmd;
    chs_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    chs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    chs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_heading_raw    (i_heading_raw),
        .i_compass_status (i_compass_status),
        .i_accel_valid    (i_accel_valid),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .o_heading_deg    (o_heading_deg),
        .o_low_accuracy   (o_low_accuracy),
        .o_has_reading    (o_has_reading)
    );

endmodule

/* bench/chs_heading_checker.sv */
`timescale 1ns / 1ps

module chs_heading_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [15:0]                   i_heading_raw,
    input  logic [1:0]                    i_compass_status,
    input  logic                          i_accel_valid,
    input  logic signed [12:0]            i_accel_x,
    input  logic signed [12:0]            i_accel_y,
    input  logic signed [12:0]            i_accel_z,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [8:0]                    i_heading_deg,
    input  logic                          i_low_accuracy,
    input  logic                          i_has_reading,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [chs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [chs_pkg::PCT_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int FRAC_BITS = chs_pkg::FRAC_BITS_DEF;
    localparam int POS_W = FRAC_BITS + 9;
    localparam int VEL_W = FRAC_BITS + 10;
    localparam longint FULL_TURN_FP = longint'(360) << FRAC_BITS;
    localparam longint VEL_MAX = (longint'(1) << (FRAC_BITS + 9)) - 1;
    localparam longint VEL_MIN = -(longint'(1) << (FRAC_BITS + 9));

    typedef struct packed {
        logic [8:0] deg;
        logic       low_acc;
        logic       seen;
    } t_heading_exp;

    logic [chs_pkg::PCT_W-1:0] gains [4];
    logic [8:0]                aim_deg;
    logic [POS_W-1:0]          pos_fp;
    logic signed [VEL_W-1:0]   vel_fp;
    logic                      seeded;
    logic                      acc_low;
    t_heading_exp              heading_due [$];
    int                        fails;

    function automatic longint clamp_velocity(input longint v);
        if (v > VEL_MAX) return VEL_MAX;
        if (v < VEL_MIN) return VEL_MIN;
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic apply_item();
        longint       rw, cw, tgt, az, axy, flat, att, fri, smooth, dlt, v, p;
        longint       at_t, af_t, ft_t, ff_t;
        t_heading_exp e;
        case (i_opcode)
            chs_pkg::OP_READ: begin
                if (i_compass_status != chs_pkg::ST_INVALID) begin
                    rw = i_heading_raw;
                    cw = 65536 - rw;
                    tgt = ((cw * 360) / 65536) % 360;
                    aim_deg = tgt[8:0];
                    acc_low = (i_compass_status != chs_pkg::ST_CALIBRATED);
                    if (!seeded) begin
                        pos_fp = POS_W'(tgt << FRAC_BITS);
                        vel_fp = '0;
                        seeded = 1'b1;
                    end
                end
            end
            chs_pkg::OP_TICK: begin
                if (seeded) begin
                    flat = 0;
                    if (i_accel_valid) begin
                        az = magnitude(longint'(i_accel_z));
                        axy = magnitude(longint'(i_accel_x)) + magnitude(longint'(i_accel_y));
                        flat = (az * 100) / (az + axy + 1);
                    end
                    at_t = gains[chs_pkg::CFG_ATT_TILT];
                    af_t = gains[chs_pkg::CFG_ATT_FLAT];
                    ft_t = gains[chs_pkg::CFG_FRI_TILT];
                    ff_t = gains[chs_pkg::CFG_FRI_FLAT];
                    att = at_t - ((at_t - af_t) * flat) / 100;
                    fri = ft_t + ((ff_t - ft_t) * flat) / 100;
                    p = pos_fp;
                    smooth = p >>> FRAC_BITS;
                    dlt = ((longint'(aim_deg) - smooth + 540) % 360) - 180;
                    v = vel_fp;
                    v = clamp_velocity(v + (dlt * (longint'(1) << FRAC_BITS) * att) / 100);
                    v = clamp_velocity((v * (100 - fri)) / 100);
                    vel_fp = v[VEL_W-1:0];
                    p = (p + v) % FULL_TURN_FP;
                    if (p < 0) p = p + FULL_TURN_FP;
                    pos_fp = p[POS_W-1:0];
                end
            end
            chs_pkg::OP_RESTART: begin
                seeded = 1'b0;
                vel_fp = '0;
            end
            default: ;
        endcase
        e.deg = 9'(pos_fp >> FRAC_BITS);
        e.low_acc = acc_low;
        e.seen = seeded;
        heading_due.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_heading_exp got;
        if (!i_rst_n) begin
            gains[chs_pkg::CFG_ATT_TILT] = chs_pkg::ATT_TILT_RST;
            gains[chs_pkg::CFG_ATT_FLAT] = chs_pkg::ATT_FLAT_RST;
            gains[chs_pkg::CFG_FRI_TILT] = chs_pkg::FRI_TILT_RST;
            gains[chs_pkg::CFG_FRI_FLAT] = chs_pkg::FRI_FLAT_RST;
            aim_deg = '0;
            pos_fp = '0;
            vel_fp = '0;
            seeded = 1'b0;
            acc_low = 1'b1;
            heading_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) gains[i_cfg_index] = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (heading_due.size() == 0) begin
                    $display("%0t unexpected item: expected none actual deg %0d", $time,
                             i_heading_deg);
                    fails++;
                end else begin
                    got = heading_due.pop_front();
                    if (i_heading_deg !== got.deg) begin
                        $display("%0t heading_deg expected %0d actual %0d", $time, got.deg,
                                 i_heading_deg);
                        fails++;
                    end
                    if (i_low_accuracy !== got.low_acc) begin
                        $display("%0t low_accuracy expected %0d actual %0d", $time,
                                 got.low_acc, i_low_accuracy);
                        fails++;
                    end
                    if (i_has_reading !== got.seen) begin
                        $display("%0t has_reading expected %0d actual %0d", $time, got.seen,
                                 i_has_reading);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) apply_item();
        end
        o_fail_count <= fails;
        o_pending <= heading_due.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] ST_CALIBRATING = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int PHASES = 7;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_opcode = '0;
    logic [15:0]                   i_heading_raw = '0;
    logic [1:0]                    i_compass_status = '0;
    logic                          i_accel_valid = 1'b0;
    logic signed [12:0]            i_accel_x = '0;
    logic signed [12:0]            i_accel_y = '0;
    logic signed [12:0]            i_accel_z = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [8:0]                    o_heading_deg;
    logic                          o_low_accuracy;
    logic                          o_has_reading;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [chs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [chs_pkg::PCT_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int gap_pct = 0;
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    compass_heading_smoother dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_heading_raw    (i_heading_raw),
        .i_compass_status (i_compass_status),
        .i_accel_valid    (i_accel_valid),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_heading_deg    (o_heading_deg),
        .o_low_accuracy   (o_low_accuracy),
        .o_has_reading    (o_has_reading),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    chs_heading_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_heading_raw    (i_heading_raw),
        .i_compass_status (i_compass_status),
        .i_accel_valid    (i_accel_valid),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_heading_deg    (o_heading_deg),
        .i_low_accuracy   (o_low_accuracy),
        .i_has_reading    (o_has_reading),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side back-pressure
    initial begin
        forever begin
            if (calm || $urandom_range(0, 1) == 0) begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    function automatic int rand_axis(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] raw,
                             input logic [1:0] st, input logic av,
                             input int ax, input int ay, input int az);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_heading_raw <= raw;
        i_compass_status <= st;
        i_accel_valid <= av;
        i_accel_x <= ax[12:0];
        i_accel_y <= ay[12:0];
        i_accel_z <= az[12:0];
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random_item();
        logic [1:0]  op;
        logic [1:0]  st;
        int          r;
        int          span_xy;
        int          span_z;
        r = $urandom_range(0, 99);
        op = (r < 28) ? chs_pkg::OP_READ : (r < 92) ? chs_pkg::OP_TICK :
             (r < 97) ? chs_pkg::OP_RESTART : OP_UNUSED;
        r = $urandom_range(0, 99);
        st = (r < 10) ? chs_pkg::ST_INVALID : (r < 35) ? ST_CALIBRATING :
             (r < 90) ? chs_pkg::ST_CALIBRATED : ST_UNKNOWN;
        r = $urandom_range(0, 2);
        span_xy = (r == 0) ? 4000 : 300;
        span_z = (r == 1) ? 300 : 4000;
        send_item(op, 16'($urandom_range(0, 65535)), st, $urandom_range(0, 9) != 0,
                  rand_axis(span_xy), rand_axis(span_xy), rand_axis(span_z));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_gain(input logic [chs_pkg::CFG_IDX_W-1:0] idx,
                              input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[chs_pkg::PCT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_gains(input int unsigned at, input int unsigned af,
                               input int unsigned ft, input int unsigned ff);
        write_gain(chs_pkg::CFG_ATT_TILT, at);
        write_gain(chs_pkg::CFG_ATT_FLAT, af);
        write_gain(chs_pkg::CFG_FRI_TILT, ft);
        write_gain(chs_pkg::CFG_FRI_FLAT, ff);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick and restart before any reading, unused opcode, invalid status
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, -4000, 4000, 4000);
        send_item(OP_UNUSED, 16'hFFFF, chs_pkg::ST_CALIBRATED, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_READ, 16'h1234, chs_pkg::ST_INVALID, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_RESTART, 16'h0000, chs_pkg::ST_INVALID, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_READ, 16'h0000, ST_UNKNOWN, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b0, 4000, 4000, 4000);
        send_item(chs_pkg::OP_READ, 16'hFFFF, chs_pkg::ST_CALIBRATED, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_READ, 16'h4000, ST_CALIBRATING, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, 0, 0, 4000);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, -4000, -4000, -4000);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, 0, 0, 0);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, 4000, 4000, 0);
        send_item(chs_pkg::OP_READ, 16'h8000, chs_pkg::ST_CALIBRATED, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b0, -4000, 4000, -4000);
        send_item(chs_pkg::OP_READ, 16'h0001, chs_pkg::ST_INVALID, 1'b0, 0, 0, 0);
        send_item(OP_UNUSED, 16'h0000, chs_pkg::ST_INVALID, 1'b1, 0, 0, 0);
        send_item(chs_pkg::OP_RESTART, 16'hFFFF, chs_pkg::ST_CALIBRATED, 1'b1, 1, 1, 1);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, 100, 200, 300);
        send_item(chs_pkg::OP_READ, 16'hC000, ST_CALIBRATING, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, 1, -1, -4000);
        send_item(chs_pkg::OP_READ, 16'h0001, chs_pkg::ST_CALIBRATED, 1'b0, 0, 0, 0);
        send_item(chs_pkg::OP_TICK, 16'h0000, chs_pkg::ST_INVALID, 1'b1, -1, 4000, 2000);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: write_gains(0, 0, 0, 0);
                    2: write_gains(100, 100, 100, 100);
                    3: write_gains(127, 127, 0, 0);
                    4: write_gains(20, 60, 127, 101);
                    default: write_gains($urandom_range(0, 127), $urandom_range(0, 127),
                                         $urandom_range(0, 127), $urandom_range(0, 127));
                endcase
            end
            calm = (ph == PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: gap_pct = 0;
                        1: gap_pct = 15;
                        default: gap_pct = 50;
                    endcase
                end
                if (n == 90) drain_results();
                send_random_item();
            end
        end

        drain_results();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
